// File: rtl/mse_pkg.sv
`timescale 1ns / 1ps

package mse_pkg;

	// request kinds carried by req_type
	typedef enum logic [1:0] {
		REQ_EXEC  = 2'd0,
		REQ_MEMWR = 2'd1,
		REQ_REGRD = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0a;
	localparam logic [5:0] OP_ANDI  = 6'h0c;
	localparam logic [5:0] OP_ORI   = 6'h0d;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2b;

	// funct codes for opcode 0
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRL = 6'h02;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_JR  = 6'h08;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_SUB = 6'h22;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR  = 6'h25;
	localparam logic [5:0] FN_NOR = 6'h27;
	localparam logic [5:0] FN_SLT = 6'h2a;

	localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
	localparam logic [31:0] RESET_PC  = 32'h0000_1000;
	localparam logic [4:0]  REG_LINK  = 5'd31;

	// register contents after reset
	function automatic logic [31:0] reg_reset_value(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd16:   v = 32'h0000_0010;
			5'd17:   v = RESET_PC;
			5'd18:   v = 32'h0000_0020;
			5'd19:   v = 32'h0000_0003;
			5'd20:   v = 32'hbada_cafe;
			5'd21:   v = 32'hcdcd_cdcd;
			5'd22:   v = 32'hffff_ffff;
			5'd23:   v = 32'h0000_0007;
			5'd29:   v = 32'h0000_8000;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/mse_ram.sv
`timescale 1ns / 1ps

module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/mips_subset_execute_unit.sv
`timescale 1ns / 1ps

// MIPS integer subset execute unit.
// Input channel (in_valid/in_ready): one transaction per request. req_type selects
// execute (instr_word), memory word preload (mem_address, mem_word) or register
// read-back (reg_index). Output channel (out_valid/out_ready): exactly one result
// transaction per request, in order: status (1 = halt word or unknown instruction,
// nothing changed), next_pc and read_value (zero unless a register read).
// An accepted request enters the execute stage and then the output register, where it
// can be taken when the receiver is ready; lw first waits in the execute stage for its
// data-memory read. Throughput: one request per cycle unless the output stalls; lw
// holds back the next request. Register operands come from two 32x32 register-file
// RAMs read at acceptance; a write landing on the same edge is forwarded.
// Data memory is four byte-lane RAMs of 2^(MEM_ADDR_BITS-2) rows, big-endian, with
// wrap-around for words crossing the top. It holds garbage until written.
// Reset: pc returns to 0x1000 and the register file reads its reset values through
// per-register valid bits; no clearing pass, requests are taken right away.
// Stall: a result waits in the output register; one further request is held in the
// execute stage, then in_ready drops until out_ready frees the output.
module mips_subset_execute_unit import mse_pkg::*; #(
	parameter int MEM_ADDR_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] instr_word,
	input  logic [19:0] mem_address,
	input  logic [31:0] mem_word,
	input  logic [4:0]  reg_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [31:0] next_pc,
	output logic [31:0] read_value
);

	localparam int ROW_BITS = MEM_ADDR_BITS - 2;
	localparam int ROWS     = 1 << ROW_BITS;

	// handshake
	logic in_accept;
	logic out_free;
	logic s1_done;

	// execute stage
	logic        valid_s1;
	req_t        req_s1;
	logic [31:0] ir_s1;
	logic [19:0] maddr_s1;
	logic [31:0] mword_s1;
	logic [4:0]  ia_s1;
	logic [4:0]  ib_s1;
	logic        va_s1;
	logic        vb_s1;
	logic        phase_q;   // lw: data memory read outstanding

	// architectural state kept in flops
	logic [31:0] pc_q;
	logic [31:0] rf_valid_q;  // register written since reset

	// same-edge write forwarding
	logic        fwd_en_q;
	logic [4:0]  fwd_idx_q;
	logic [31:0] fwd_data_q;

	// output register
	logic        out_valid_q;
	logic        status_q;
	logic [31:0] next_pc_q;
	logic [31:0] read_value_q;

	// register file RAMs
	logic [4:0]  rf_rd_addr_a;
	logic [31:0] rf_rdata_a;
	logic [31:0] rf_rdata_b;
	logic        rf_wr;

	// decode / datapath
	logic [31:0] a_val;
	logic [31:0] b_val;
	logic [31:0] pc4;
	logic [31:0] imm_sx;
	logic [31:0] imm_zx;
	logic        halt;
	logic        wr_en;
	logic [4:0]  wr_idx;
	logic [31:0] wr_val;
	logic [31:0] pc_nxt;
	logic        is_load;
	logic        is_store;
	logic [31:0] st_addr;
	logic [31:0] st_data;
	logic [31:0] rd_val;
	logic [31:0] load_word;

	// data memory lanes
	logic [MEM_ADDR_BITS-1:0] baddr;
	logic [1:0]               boff;
	logic [ROW_BITS-1:0]      brow;
	logic [ROW_BITS-1:0]      lane_row   [4];
	logic [7:0]               lane_wdata [4];
	logic [7:0]               lane_rdata [4];
	logic                     mem_wr;
	logic                     mem_rd_en;

	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign s1_done   = valid_s1 && out_free && (!is_load || phase_q);
	assign in_ready  = !valid_s1 || s1_done;
	assign rf_wr     = s1_done && wr_en && (wr_idx != 5'd0);
	assign mem_wr    = s1_done && is_store;
	assign mem_rd_en = valid_s1 && is_load && !phase_q;

	assign rf_rd_addr_a = (req_type == REQ_REGRD) ? reg_index : instr_word[25:21];

	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk     (clk),
		.wr_en   (rf_wr),
		.wr_addr (wr_idx),
		.wr_data (wr_val),
		.rd_en   (in_accept),
		.rd_addr (rf_rd_addr_a),
		.rd_data (rf_rdata_a)
	);

	mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk     (clk),
		.wr_en   (rf_wr),
		.wr_addr (wr_idx),
		.wr_data (wr_val),
		.rd_en   (in_accept),
		.rd_addr (instr_word[20:16]),
		.rd_data (rf_rdata_b)
	);

	// operand select: forwarded write, then RAM if written, else reset value
	always_comb begin
		if (fwd_en_q && fwd_idx_q == ia_s1)
			a_val = fwd_data_q;
		else if (va_s1)
			a_val = rf_rdata_a;
		else
			a_val = reg_reset_value(ia_s1);
		if (fwd_en_q && fwd_idx_q == ib_s1)
			b_val = fwd_data_q;
		else if (vb_s1)
			b_val = rf_rdata_b;
		else
			b_val = reg_reset_value(ib_s1);
	end

	// instruction decode and execute
	always_comb begin
		pc4      = pc_q + 32'd4;
		imm_sx   = {{16{ir_s1[15]}}, ir_s1[15:0]};
		imm_zx   = {16'h0000, ir_s1[15:0]};
		halt     = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = ir_s1[15:11];
		wr_val   = 32'h0;
		pc_nxt   = pc_q;
		is_load  = 1'b0;
		is_store = 1'b0;
		st_addr  = a_val + imm_sx;
		st_data  = b_val;
		rd_val   = 32'h0;
		unique case (req_s1)
			REQ_EXEC: begin
				if (ir_s1 == HALT_WORD) begin
					halt = 1'b1;
				end else begin
					pc_nxt = pc4;
					unique case (ir_s1[31:26])
						OP_RTYPE: begin
							wr_en  = 1'b1;
							wr_idx = ir_s1[15:11];
							unique case (ir_s1[5:0])
								FN_ADD: wr_val = a_val + b_val;
								FN_SUB: wr_val = a_val - b_val;
								FN_AND: wr_val = a_val & b_val;
								FN_OR:  wr_val = a_val | b_val;
								FN_NOR: wr_val = ~(a_val | b_val);
								FN_SLL: wr_val = b_val << ir_s1[10:6];
								FN_SRL: wr_val = b_val >> ir_s1[10:6];
								FN_SRA: wr_val = $unsigned($signed(b_val) >>> ir_s1[10:6]);
								FN_SLT: wr_val = {31'h0, $signed(a_val) < $signed(b_val)};
								FN_JR: begin
									wr_en  = 1'b0;
									pc_nxt = a_val;
								end
								default: begin
									halt   = 1'b1;
									wr_en  = 1'b0;
									pc_nxt = pc_q;
								end
							endcase
						end
						OP_J: pc_nxt = {pc4[31:28], ir_s1[25:0], 2'b00};
						OP_JAL: begin
							wr_en  = 1'b1;
							wr_idx = REG_LINK;
							wr_val = pc4;
							pc_nxt = {pc4[31:28], ir_s1[25:0], 2'b00};
						end
						OP_ADDI: begin
							wr_en  = 1'b1;
							wr_idx = ir_s1[20:16];
							wr_val = a_val + imm_sx;
						end
						OP_ANDI: begin
							wr_en  = 1'b1;
							wr_idx = ir_s1[20:16];
							wr_val = a_val & imm_zx;
						end
						OP_ORI: begin
							wr_en  = 1'b1;
							wr_idx = ir_s1[20:16];
							wr_val = a_val | imm_zx;
						end
						OP_SLTI: begin
							wr_en  = 1'b1;
							wr_idx = ir_s1[20:16];
							wr_val = {31'h0, $signed(a_val) < $signed(imm_sx)};
						end
						OP_LW: begin
							is_load = 1'b1;
							wr_en   = 1'b1;
							wr_idx  = ir_s1[20:16];
							wr_val  = load_word;
						end
						OP_SW: is_store = 1'b1;
						OP_BEQ: begin
							if (a_val == b_val)
								pc_nxt = pc4 + {imm_sx[29:0], 2'b00};
						end
						OP_BNE: begin
							if (a_val != b_val)
								pc_nxt = pc4 + {imm_sx[29:0], 2'b00};
						end
						default: begin
							halt   = 1'b1;
							pc_nxt = pc_q;
						end
					endcase
				end
			end
			REQ_MEMWR: begin
				is_store = 1'b1;
				st_addr  = 32'(maddr_s1);
				st_data  = mword_s1;
			end
			REQ_REGRD: rd_val = a_val;
			default: ;
		endcase
	end

	// byte lanes: lane L holds byte addresses with addr[1:0] == L; a word
	// starting at offset boff spills into the next row for lanes below boff
	assign baddr = st_addr[MEM_ADDR_BITS-1:0];
	assign boff  = baddr[1:0];
	assign brow  = baddr[MEM_ADDR_BITS-1:2];

	always_comb begin
		logic [1:0] lane;
		logic [1:0] bidx;
		for (int l = 0; l < 4; l++) begin
			lane          = 2'(l);
			bidx          = lane - boff;
			lane_row[l]   = brow + ROW_BITS'(lane < boff);
			lane_wdata[l] = st_data[{~bidx, 3'b000} +: 8];
		end
	end

	always_comb begin
		logic [1:0] bsel;
		logic [1:0] lsel;
		load_word = 32'h0;
		for (int i = 0; i < 4; i++) begin
			bsel = 2'(i);
			lsel = boff + bsel;
			load_word[{~bsel, 3'b000} +: 8] = lane_rdata[lsel];
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_dmem (
			.clk     (clk),
			.wr_en   (mem_wr),
			.wr_addr (lane_row[g]),
			.wr_data (lane_wdata[g]),
			.rd_en   (mem_rd_en),
			.rd_addr (lane_row[g]),
			.rd_data (lane_rdata[g])
		);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= RESET_PC;
			rf_valid_q  <= '0;
			fwd_en_q    <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (s1_done)
				valid_s1 <= 1'b0;
			if (s1_done)
				phase_q <= 1'b0;
			else if (mem_rd_en)
				phase_q <= 1'b1;
			if (s1_done)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (s1_done)
				pc_q <= pc_nxt;
			if (rf_wr)
				rf_valid_q[wr_idx] <= 1'b1;
			// forward only a write that coincides with the operand read
			if (rf_wr || in_accept)
				fwd_en_q <= rf_wr;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1   <= req_t'(req_type);
			ir_s1    <= instr_word;
			maddr_s1 <= mem_address;
			mword_s1 <= mem_word;
			ia_s1    <= rf_rd_addr_a;
			ib_s1    <= instr_word[20:16];
			va_s1    <= rf_valid_q[rf_rd_addr_a];
			vb_s1    <= rf_valid_q[instr_word[20:16]];
		end
		if (rf_wr) begin
			fwd_idx_q  <= wr_idx;
			fwd_data_q <= wr_val;
		end
		if (s1_done) begin
			status_q     <= halt;
			next_pc_q    <= pc_nxt;
			read_value_q <= rd_val;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign next_pc    = next_pc_q;
	assign read_value = read_value_q;

endmodule

// File: rtl/mse_checker.sv
`timescale 1ns / 1ps

module mse_checker import mse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  req_type,
	input logic [4:0]  reg_index,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic [31:0] next_pc,
	input logic [31:0] read_value
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(next_pc)
			&& $stable(read_value))
		else $error("result changed while stalled");

	// halt results never carry register data
	a_halt_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_value == 32'h0)
		else $error("halt result with read data");

	// r0 read-back returns zero with status clear once the receiver is ready after acceptance
	a_r0_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_REGRD && reg_index == 5'd0)
			##1 out_ready |=> out_valid && status == 1'b0 && read_value == 32'h0)
		else $error("r0 read-back wrong or late");

	// a preload completes with no halt and no read data
	a_preload: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_MEMWR)
			##1 out_ready |=> out_valid && status == 1'b0 && read_value == 32'h0)
		else $error("preload result wrong or late");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (.*);
